// ===== rtl/core/psd_pkg.sv =====
// ----------------------------------------------------------------------------
// psd_pkg
// Shared constants and types for the point to segment distance pipeline.
// ----------------------------------------------------------------------------
package psd_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int T_FRAC_BITS_DEF = 16;

    typedef enum logic [1:0] {
        SEL_ZERO,
        SEL_ONE,
        SEL_FRAC
    } t_sel_t;

endpackage

// ===== rtl/core/psd_front.sv =====
// ----------------------------------------------------------------------------
// psd_front
// Offsets, products and sums: p - a, b - a, dot product and squared length.
// ----------------------------------------------------------------------------
module psd_front #(
    parameter int W = 24
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [9*W-1:0]          coords,
    output logic                    out_valid,
    output logic signed [2*W+3:0]   dot,
    output logic [2*W+3:0]          len2,
    output logic [6*(W+1)-1:0]      payload
);
    import psd_pkg::*;

    localparam int DW = W + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 2;

    logic signed [DW-1:0] pa_reg [3];
    logic signed [DW-1:0] d_reg [3];
    logic signed [DW-1:0] pa2_reg [3];
    logic signed [DW-1:0] d2_reg [3];
    logic signed [DW-1:0] pa3_reg [3];
    logic signed [DW-1:0] d3_reg [3];
    logic signed [PW-1:0] pd_reg [3];
    logic signed [PW-1:0] dd_reg [3];
    logic signed [SW-1:0] dot_reg;
    logic [SW-1:0]        len2_reg;
    logic [2:0]           v_reg;

    logic signed [DW-1:0] pa_next [3];
    logic signed [DW-1:0] d_next [3];
    logic signed [SW-1:0] dot_next;
    logic signed [SW-1:0] len2_next;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pa_next[i] = $signed({coords[i*W+W-1], coords[i*W +: W]})
                       - $signed({coords[(3+i)*W+W-1], coords[(3+i)*W +: W]});
            d_next[i]  = $signed({coords[(6+i)*W+W-1], coords[(6+i)*W +: W]})
                       - $signed({coords[(3+i)*W+W-1], coords[(3+i)*W +: W]});
        end
        dot_next  = '0;
        len2_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            dot_next  = dot_next + $signed({{2{pd_reg[i][PW-1]}}, pd_reg[i]});
            len2_next = len2_next + $signed({{2{dd_reg[i][PW-1]}}, dd_reg[i]});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pa_reg[i]  <= pa_next[i];
                d_reg[i]   <= d_next[i];
                pd_reg[i]  <= pa_reg[i] * d_reg[i];
                dd_reg[i]  <= d_reg[i] * d_reg[i];
                pa2_reg[i] <= pa_reg[i];
                d2_reg[i]  <= d_reg[i];
                pa3_reg[i] <= pa2_reg[i];
                d3_reg[i]  <= d2_reg[i];
            end
            dot_reg  <= dot_next;
            len2_reg <= len2_next;
        end
    end

    assign out_valid = v_reg[2];
    assign dot       = dot_reg;
    assign len2      = len2_reg;
    assign payload   = {d3_reg[2], d3_reg[1], d3_reg[0],
                        pa3_reg[2], pa3_reg[1], pa3_reg[0]};

endmodule

// ===== rtl/core/psd_div.sv =====
// ----------------------------------------------------------------------------
// psd_div
// Segment parameter: restoring division, one quotient bit per stage.
// ----------------------------------------------------------------------------
module psd_div #(
    parameter int SW  = 52,
    parameter int F   = 16,
    parameter int PLW = 150
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic signed [SW-1:0] dot,
    input  logic [SW-1:0]        len2,
    input  logic [PLW-1:0]       pl_in,
    output logic                 out_valid,
    output logic [F:0]           t,
    output logic [PLW-1:0]       pl_out
);
    import psd_pkg::*;

    logic [SW:0]    rem_reg [F+1];
    logic [SW-1:0]  den_reg [F+1];
    logic [F:0]     q_reg [F+1];
    t_sel_t         sel_reg [F+1];
    logic [PLW-1:0] pl_reg [F+1];
    logic [F:0]     v_reg;

    t_sel_t sel_next;

    always_comb
    begin
        if (len2 == '0 || dot[SW-1] || dot == '0)
        begin
            sel_next = SEL_ZERO;
        end
        else if ($unsigned(dot) >= len2)
        begin
            sel_next = SEL_ONE;
        end
        else
        begin
            sel_next = SEL_FRAC;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[F-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= {1'b0, dot};
            den_reg[0] <= len2;
            q_reg[0]   <= '0;
            sel_reg[0] <= sel_next;
            pl_reg[0]  <= pl_in;
        end
    end

    for (genvar k = 1; k <= F; k++)
    begin : g_stage
        logic [SW:0] rem2;
        assign rem2 = {rem_reg[k-1][SW-1:0], 1'b0};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem2 >= {1'b0, den_reg[k-1]})
                begin
                    rem_reg[k] <= rem2 - {1'b0, den_reg[k-1]};
                    q_reg[k]   <= {q_reg[k-1][F-1:0], 1'b1};
                end
                else
                begin
                    rem_reg[k] <= rem2;
                    q_reg[k]   <= {q_reg[k-1][F-1:0], 1'b0};
                end
                den_reg[k] <= den_reg[k-1];
                sel_reg[k] <= sel_reg[k-1];
                pl_reg[k]  <= pl_reg[k-1];
            end
        end
    end

    always_comb
    begin
        case (sel_reg[F])
            SEL_ZERO: t = '0;
            SEL_ONE:  t = {1'b1, {F{1'b0}}};
            SEL_FRAC: t = q_reg[F];
            default:  t = '0;
        endcase
    end

    assign out_valid = v_reg[F];
    assign pl_out    = pl_reg[F];

endmodule

// ===== rtl/core/psd_err.sv =====
// ----------------------------------------------------------------------------
// psd_err
// Closest point offset, error vector and squared error.
// ----------------------------------------------------------------------------
module psd_err #(
    parameter int W = 24,
    parameter int F = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [F:0]             t,
    input  logic [6*(W+1)-1:0]     pl,
    output logic                   out_valid,
    output logic [2*(W+2)+1:0]     err2
);
    import psd_pkg::*;

    localparam int DW = W + 1;
    localparam int OW = F + 1 + DW;
    localparam int EW = DW + 2;
    localparam int MW = DW + 1;
    localparam int QW = 2 * MW;
    localparam int ES = QW + 2;
    localparam logic [OW-1:0] ROUND = OW'((1 << F) - 1);

    logic [OW-1:0]        prod_reg [3];
    logic                 neg_reg [3];
    logic signed [DW-1:0] pa_reg [3];
    logic [MW-1:0]        m_reg [3];
    logic [QW-1:0]        sq_reg [3];
    logic [ES-1:0]        sum_reg;
    logic [3:0]           v_reg;

    logic signed [DW-1:0] pa_in [3];
    logic signed [DW-1:0] d_in [3];
    logic [DW-1:0]        dmag [3];
    logic [OW-1:0]        qfull [3];
    logic signed [EW-1:0] off [3];
    logic signed [EW-1:0] e [3];
    logic [MW-1:0]        m_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pa_in[i] = pl[i*DW +: DW];
            d_in[i]  = pl[(3+i)*DW +: DW];
            dmag[i]  = d_in[i][DW-1] ? DW'(-d_in[i]) : DW'(d_in[i]);
            qfull[i] = neg_reg[i] ? ((prod_reg[i] + ROUND) >> F) : (prod_reg[i] >> F);
            off[i]   = neg_reg[i] ? -$signed({2'b00, qfull[i][DW-1:0]})
                                  : $signed({2'b00, qfull[i][DW-1:0]});
            e[i]     = $signed({{2{pa_reg[i][DW-1]}}, pa_reg[i]}) - off[i];
            m_next[i] = e[i][EW-1] ? MW'(-e[i]) : MW'(e[i]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i] <= OW'(t) * OW'(dmag[i]);
                neg_reg[i]  <= d_in[i][DW-1];
                pa_reg[i]   <= pa_in[i];
                m_reg[i]    <= m_next[i];
                sq_reg[i]   <= m_reg[i] * m_reg[i];
            end
            sum_reg <= ES'(sq_reg[0]) + ES'(sq_reg[1]) + ES'(sq_reg[2]);
        end
    end

    assign out_valid = v_reg[3];
    assign err2      = sum_reg;

endmodule

// ===== rtl/core/psd_sqrt.sv =====
// ----------------------------------------------------------------------------
// psd_sqrt
// Integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module psd_sqrt #(
    parameter int ES = 56,
    parameter int OW = 25
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [ES-1:0] n,
    output logic          out_valid,
    output logic [OW-1:0] root
);
    import psd_pkg::*;

    localparam int RB = ES / 2;

    logic [ES-1:0] n_reg [RB];
    logic [ES-1:0] res_reg [RB];
    logic [RB-1:0] v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[RB-2:0], in_valid};
        end
    end

    for (genvar k = 0; k < RB; k++)
    begin : g_stage
        localparam logic [ES-1:0] BIT = ES'(1) << (ES - 2 - 2 * k);
        logic [ES-1:0] n_cur;
        logic [ES-1:0] r_cur;
        logic [ES-1:0] trial;

        if (k == 0)
        begin : g_first
            assign n_cur = n;
            assign r_cur = '0;
        end
        else
        begin : g_rest
            assign n_cur = n_reg[k-1];
            assign r_cur = res_reg[k-1];
        end

        assign trial = r_cur + BIT;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (n_cur >= trial)
                begin
                    n_reg[k]   <= n_cur - trial;
                    res_reg[k] <= (r_cur >> 1) + BIT;
                end
                else
                begin
                    n_reg[k]   <= n_cur;
                    res_reg[k] <= r_cur >> 1;
                end
            end
        end
    end

    assign out_valid = v_reg[RB-1];
    assign root      = res_reg[RB-1][OW-1:0];

endmodule

// ===== rtl/core/point_segment_distance.sv =====
// ----------------------------------------------------------------------------
// point_segment_distance
// Distance from a 3D point to a line segment, fully pipelined.
// ----------------------------------------------------------------------------
// Accepts one request per cycle while the output is not stalled and returns
// one distance per request, in order. The segment parameter comes from a
// one-bit-per-stage divider and the distance from a one-bit-per-stage square
// root. A stall on the output holds the whole pipeline.
module point_segment_distance #(
    parameter int COORD_WIDTH = psd_pkg::COORD_WIDTH_DEF,
    parameter int T_FRAC_BITS = psd_pkg::T_FRAC_BITS_DEF
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      s_tvalid,
    output logic                                      s_tready,
    // point_x, point_y, point_z, start_x, start_y, start_z, end_x, end_y, end_z
    input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]        s_tdata,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    // distance
    output logic [((COORD_WIDTH+1+7)/8)*8-1:0]        m_tdata
);
    import psd_pkg::*;

    localparam int W   = COORD_WIDTH;
    localparam int F   = T_FRAC_BITS;
    localparam int DW  = W + 1;
    localparam int SW  = 2 * DW + 2;
    localparam int PLW = 6 * DW;
    localparam int ES  = 2 * (DW + 1) + 2;
    localparam int OBW = ((W + 1 + 7) / 8) * 8;

    logic                 en;
    logic                 f_valid;
    logic signed [SW-1:0] f_dot;
    logic [SW-1:0]        f_len2;
    logic [PLW-1:0]       f_pl;
    logic                 d_valid;
    logic [F:0]           d_t;
    logic [PLW-1:0]       d_pl;
    logic                 e_valid;
    logic [ES-1:0]        e_err2;
    logic [W:0]           root_val;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    psd_front #(.W(W)) u_front (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(s_tvalid), .coords(s_tdata[9*W-1:0]),
        .out_valid(f_valid), .dot(f_dot), .len2(f_len2), .payload(f_pl)
    );

    psd_div #(.SW(SW), .F(F), .PLW(PLW)) u_div (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(f_valid), .dot(f_dot), .len2(f_len2), .pl_in(f_pl),
        .out_valid(d_valid), .t(d_t), .pl_out(d_pl)
    );

    psd_err #(.W(W), .F(F)) u_err (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(d_valid), .t(d_t), .pl(d_pl),
        .out_valid(e_valid), .err2(e_err2)
    );

    psd_sqrt #(.ES(ES), .OW(W + 1)) u_sqrt (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(e_valid), .n(e_err2),
        .out_valid(m_tvalid), .root(root_val)
    );

    assign m_tdata = OBW'(root_val);

endmodule
